### design/mse_pkg.sv
// Shared types, constants and parity helper for the Mode S frame encoder.
`timescale 1ns / 1ps
`default_nettype none
package mse_pkg;

    localparam int ChipMax = 64;
    localparam int LenW    = 7;
    localparam int CrcW    = 24;
    localparam int CntW    = 4;

    localparam logic [CrcW-1:0] CRC_POLY  = 24'hFFF409;
    localparam logic [15:0]     PREAMBLE  = 16'b0000_0010_1000_0101; // chip 0 in bit 0
    localparam logic [CntW-1:0] LEN_LONG  = 4'd11;
    localparam logic [CntW-1:0] LEN_SHORT = 4'd4;

    localparam logic [LenW-1:0] RUN_DATA  = 7'd16;
    localparam logic [LenW-1:0] RUN_PRE   = 7'd32;
    localparam logic [LenW-1:0] RUN_LAST  = 7'd64;

    typedef struct packed {
        logic [ChipMax-1:0] chips;     // chip 0 in bit 0
        logic [LenW-1:0]    len;
        logic               frame_end;
    } run_t;

    // one byte through the MSB-first parity register
    function automatic logic [CrcW-1:0] crc_byte(input logic [CrcW-1:0] crc_in,
                                                 input logic [7:0] d);
        logic [CrcW-1:0] c;
        logic            fb;
        c = crc_in;
        for (int i = 7; i >= 0; i--) begin
            fb = c[CrcW-1] ^ d[i];
            c  = {c[CrcW-2:0], 1'b0} ^ (fb ? CRC_POLY : '0);
        end
        return c;
    endfunction

endpackage
`default_nettype wire

### design/mse_calc.sv
// Per-byte stage: parity update, frame counting and chip run build.
`timescale 1ns / 1ps
`default_nettype none
module mse_calc
    import mse_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic       cfg_data,
    output logic            run_valid,
    output run_t            run,
    input  wire logic       run_take
);

    logic [CrcW-1:0] par_reg, par_next;
    logic [CntW-1:0] cnt_reg, cnt_next;
    logic            long_reg;
    logic            pend_reg;
    run_t            run_reg, run_next;

    logic [CrcW-1:0] crc_new;
    logic [CntW-1:0] cnt1;
    logic [CntW-1:0] frame_len;
    logic            first, last;
    logic [15:0]     dchips;
    logic [47:0]     pchips;
    logic            accept;

    assign cfg_ready = 1'b1;
    assign s_tready  = !pend_reg || run_take;
    assign accept    = s_tvalid && s_tready;
    assign run_valid = pend_reg;
    assign run       = run_reg;

    always_comb begin
        first     = (cnt_reg == '0);
        crc_new   = crc_byte(first ? '0 : par_reg, s_tdata);
        cnt1      = cnt_reg + 4'd1;
        frame_len = long_reg ? LEN_LONG : LEN_SHORT;
        last      = (cnt1 >= frame_len) || (cnt1 == '0);
        for (int j = 0; j < 8; j++) begin
            dchips[2*j]   = s_tdata[7-j];
            dchips[2*j+1] = ~s_tdata[7-j];
        end
        for (int j = 0; j < 24; j++) begin
            pchips[2*j]   = crc_new[23-j];
            pchips[2*j+1] = ~crc_new[23-j];
        end
        // preamble and parity never fall on the same byte
        if (first) begin
            run_next.chips = {32'd0, dchips, PREAMBLE};
            run_next.len   = RUN_PRE;
        end else if (last) begin
            run_next.chips = {pchips, dchips};
            run_next.len   = RUN_LAST;
        end else begin
            run_next.chips = {48'd0, dchips};
            run_next.len   = RUN_DATA;
        end
        run_next.frame_end = last;
        par_next = last ? '0 : crc_new;
        cnt_next = last ? '0 : cnt1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            par_reg  <= '0;
            cnt_reg  <= '0;
            long_reg <= 1'b1;
            pend_reg <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                long_reg <= cfg_data;
            end
            if (accept) begin
                par_reg  <= par_next;
                cnt_reg  <= cnt_next;
                pend_reg <= 1'b1;
            end else if (run_take) begin
                pend_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            run_reg <= run_next;
        end
    end

endmodule
`default_nettype wire

### design/mse_ser.sv
// Chip serializer: shifts one run out at one chip per beat.
`timescale 1ns / 1ps
`default_nettype none
module mse_ser
    import mse_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       run_valid,
    input  run_t            run,
    output logic            run_take,
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,
    output logic            m_tlast,
    output logic            m_tuser
);

    logic [ChipMax-1:0] shift_reg;
    logic [LenW-1:0]    left_reg;
    logic               fend_reg;
    logic               free;

    assign m_tvalid = (left_reg != '0);
    assign m_tlast  = (left_reg == 7'd1);
    assign m_tdata  = {7'd0, shift_reg[0]};
    assign m_tuser  = m_tlast && fend_reg;
    assign free     = !m_tvalid || (m_tlast && m_tready);
    assign run_take = run_valid && free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_reg <= '0;
        end else if (run_take) begin
            left_reg <= run.len;
        end else if (m_tvalid && m_tready) begin
            left_reg <= left_reg - 7'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (run_take) begin
            shift_reg <= run.chips;
            fend_reg  <= run.frame_end;
        end else if (m_tvalid && m_tready) begin
            shift_reg <= {1'b0, shift_reg[ChipMax-1:1]};
        end
    end

endmodule
`default_nettype wire

### design/mode_s_frame_ppm_encoder.sv
// Mode S frame encoder top level: byte stream in, PPM chip stream out.
//
// s_ channel: one data byte per beat, MSB sent first. The first byte of a
// frame is preceded by the 16-chip preamble; the last byte (4th or 11th, set
// by long_frame) is followed by the 24 parity bits as 48 PPM chips.
// m_ channel: one chip per beat in m_tdata[0]; m_tlast marks the last chip
// of each byte's run, m_tuser marks the final parity chip of the frame.
// cfg channel: writes long_frame (reset 1); always ready, write when idle.
// A taken byte's run is registered in the run register and then loaded into
// the serializer's shift register once the serializer is free.
// Throughput: one chip per cycle while m_tready is high, set by the
// serializer; a byte is 16 chips (32 for the first, 64 for the last byte).
// One byte is held in the run register while the previous run shifts out.
// Reset clears parity, byte count and both stages and sets long_frame.
// When m_tready is low the current chip holds and input stalls once the run
// register is full.
`timescale 1ns / 1ps
`default_nettype none
module mode_s_frame_ppm_encoder
    import mse_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] data_byte
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,   // [0] chip, [7:1] zero
    output logic            m_tlast,
    output logic            m_tuser,   // [0] frame_end
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic       cfg_data
);

    logic run_valid;
    logic run_take;
    run_t run;

    mse_calc u_calc (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .run_valid (run_valid),
        .run       (run),
        .run_take  (run_take)
    );

    mse_ser u_ser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .run_valid (run_valid),
        .run       (run),
        .run_take  (run_take),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

endmodule
`default_nettype wire

### design/mse_checker.sv
// Port-level checks for the Mode S frame encoder, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module mse_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       m_tvalid,
    input wire logic       m_tready,
    input wire logic [7:0] m_tdata,
    input wire logic       m_tlast,
    input wire logic       m_tuser
);

    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("m_tvalid high after reset");

    a_fend_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tlast)
        else $error("frame end off a run end");

    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[7:1] == 7'd0)
        else $error("chip pad bits not zero");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled beat changed");

endmodule

bind mode_s_frame_ppm_encoder mse_checker u_mse_checker (.*);
`default_nettype wire
